// ===== hdl/pps_discipline_loop_assert.svh =====
// ----------------------------------------------------------------------------
// pps discipline loop assertion macros
// property helpers used by the asserting design file
// ----------------------------------------------------------------------------
`ifndef PPS_DISCIPLINE_LOOP_ASSERT_SVH
`define PPS_DISCIPLINE_LOOP_ASSERT_SVH

// same-cycle implication
`define PDL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pdl assertion failed");

// next-cycle implication
`define PDL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pdl assertion failed");

`endif

// ===== hdl/pdl_pkg.sv =====
// ----------------------------------------------------------------------------
// pdl_pkg
// shared types and constants of the pps discipline loop
// ----------------------------------------------------------------------------
package pdl_pkg;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROD,
    ST_ERR,
    ST_UPD,
    ST_SUM,
    ST_MDIV_GO,
    ST_MDIV_WAIT,
    ST_SQ,
    ST_VDIV_GO,
    ST_VDIV_WAIT,
    ST_ROOT_GO,
    ST_ROOT_WAIT,
    ST_DONE
  } pdl_state_t;

  // status of a multi-cycle arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } pdl_unit_sts_t;

  // error ring depth, a power of two so the mean and variance divide is a shift
  localparam int RING_DEPTH = 64;

  localparam logic CFG_MAX_ALIGN = 1'b0;
  localparam logic CFG_SETTLE    = 1'b1;

  localparam logic [11:0] DAC_MAX = 12'd4095;
  localparam logic [11:0] DAC_MID = 12'd2048;
  localparam logic [15:0] MAX_ALIGN_RST = 16'd2;
  localparam logic [15:0] SETTLE_RST    = 16'd25;

  localparam int ERR_MAX = 32767;
  localparam int ERR_MIN = -32768;

endpackage

// ===== hdl/pdl_ring_mem.sv =====
// ----------------------------------------------------------------------------
// pdl_ring_mem
// error ring store, one write and one registered read port
// ----------------------------------------------------------------------------
module pdl_ring_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 17
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/pdl_div.sv =====
// ----------------------------------------------------------------------------
// pdl_div
// divide by a power of two as a registered shift, result in the cycle after start
// ----------------------------------------------------------------------------
module pdl_div #(
  parameter int DW = 38,
  parameter int SH = 6
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [DW-1:0]          dividend,
  output logic [DW-1:0]          quotient,
  output pdl_pkg::pdl_unit_sts_t sts
);
  import pdl_pkg::*;

  logic [DW-1:0] quo_r;
  logic          done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend >> SH;
    end
  end

  assign quotient = quo_r;
  assign sts      = '{busy: 1'b0, done: done_r};

endmodule

// ===== hdl/pdl_sqrt.sv =====
// ----------------------------------------------------------------------------
// pdl_sqrt
// floor square root, one result bit per cycle
// ----------------------------------------------------------------------------
module pdl_sqrt (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [31:0]            radicand,
  output logic [15:0]            root,
  output pdl_pkg::pdl_unit_sts_t sts
);
  import pdl_pkg::*;

  logic [31:0] op_r;
  logic [15:0] res_r;
  logic [17:0] rem_r;
  logic [3:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [17:0] rem_t;
  logic [17:0] trial;
  logic        fits;

  assign rem_t = {rem_r[15:0], op_r[31:30]};
  assign trial = {res_r, 2'b01};
  assign fits  = (rem_t >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 4'd15) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_r  <= radicand;
      res_r <= '0;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      op_r  <= {op_r[29:0], 2'b00};
      rem_r <= fits ? (rem_t - trial) : rem_t;
      res_r <= {res_r[14:0], fits};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign root = res_r;
  assign sts  = '{busy: busy_r, done: done_r};

endmodule

// ===== hdl/pps_discipline_loop.sv =====
// ----------------------------------------------------------------------------
// pps_discipline_loop
// bang-bang oscillator discipline loop with error ring statistics
// ----------------------------------------------------------------------------
// one item per reference pps edge. the block forms the wrapped coarse gap and
// the saturated fine phase error, steps the 12-bit dac code, writes the error
// and realign mark into the ring memory, then walks the ring twice (sum and
// lock, then squared deviation), divides by the ring depth with a shift and
// takes a serial square root. the input stays stalled from acceptance until
// the item is through the two ring walks on the single read port, the
// 16-step square root and the output register. after reset a clearing pass
// zeroes the ring before the first item is taken. the result sits in an
// output register, so the next item can enter while it waits to be taken.
module pps_discipline_loop #(
  parameter int FINE_DIVISOR  = 400,
  parameter int COARSE_PERIOD = 62500
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_ref_coarse,
  input  logic [$clog2(FINE_DIVISOR)-1:0] in_ref_fine,
  input  logic [15:0] in_loop_coarse,
  input  logic [$clog2(FINE_DIVISOR)-1:0] in_loop_fine,
  input  logic        in_sense_bit,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_dac_code,
  output logic [15:0] out_pulse_start,
  output logic [15:0] out_pulse_end,
  output logic        out_pulse_inverted,
  output logic        out_realigned,
  output logic signed [15:0] out_phase_error,
  output logic signed [15:0] out_mean_error,
  output logic [15:0] out_rms_error,
  output logic        out_locked,
  output logic        out_settled,
  output logic [7:0]  out_second_count
);
  import pdl_pkg::*;

  // widths
  localparam int AW   = $clog2(RING_DEPTH);
  localparam int FW   = $clog2(FINE_DIVISOR);
  localparam int PHW  = 16 + FW;          // coarse*fine+fine phase
  localparam int DW   = PHW + 2;          // signed phase difference after wrap
  localparam int GW   = 18;               // signed coarse gap after wrap
  localparam int SUMW = 17 + AW;
  localparam int SQW  = 32 + AW;

  // wrap limits
  localparam int P2    = COARSE_PERIOD * FINE_DIVISOR;
  localparam int P2_HI = P2 - P2 / 2 - 1;
  localparam int P2_LO = -(P2 / 2);
  localparam int P1_HI = COARSE_PERIOD - COARSE_PERIOD / 2 - 1;
  localparam int P1_LO = -(COARSE_PERIOD / 2);
  localparam int PW    = COARSE_PERIOD / 10;

  localparam logic [AW:0]   DEPTH_C = (AW + 1)'(RING_DEPTH);
  localparam logic [AW-1:0] LAST_C  = AW'(RING_DEPTH - 1);

  // control state
  pdl_state_t state_r, state_nxt;

  // configuration registers
  logic [15:0] max_align_r;
  logic [15:0] settle_lim_r;

  // loop state
  logic [11:0]        dac_r;
  logic signed [15:0] last_err_r;
  logic [15:0]        offset_r;
  logic [AW-1:0]      ptr_r;
  logic [7:0]         sec_r;
  logic [AW-1:0]      clr_r;

  // captured item
  logic [15:0]   rc_r, lc_r;
  logic [FW-1:0] rf_r, lf_r;
  logic          sense_r;

  // per-item working values
  logic [PHW-1:0]     rph_r, lph_r;
  logic signed [15:0] err_r;
  logic               mark_r;
  logic [AW:0]        walk_r;
  logic               rd_vld_r;
  logic signed [SUMW-1:0] sum_r;
  logic               lock_r;
  logic signed [15:0] mean_r;
  logic signed [16:0] d_r;
  logic               d_vld_r;
  logic [31:0]        sqp_r;
  logic               p_vld_r;
  logic [SQW-1:0]     sq_r;

  // output register
  logic        out_valid_r;
  logic [11:0] out_dac_r;
  logic [15:0] out_start_r, out_end_r, out_rms_r;
  logic        out_inv_r, out_mark_r, out_locked_r, out_settled_r;
  logic signed [15:0] out_err_r, out_mean_r;
  logic [7:0]  out_sec_r;

  // control outputs of the sequencer
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [16:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [16:0]   mem_rdata;
  logic          walk_issue;
  logic          div_start;
  logic [SQW-1:0] div_dividend;
  logic [SQW-1:0] div_quo;
  pdl_unit_sts_t div_sts;
  logic          root_start;
  logic [15:0]   root_val;
  pdl_unit_sts_t root_sts;
  logic          out_load;
  logic          walk_end;

  // combinational datapath
  logic signed [DW-1:0]   ph_d, ph_w1, ph_w2;
  logic signed [GW-1:0]   gap_d, gap_w1, gap_w2, gap_abs;
  logic signed [15:0]     err_sat;
  logic signed [16:0]     change;
  logic signed [SUMW-1:0] sum_abs;
  logic signed [16:0]     rd_err_x;
  logic signed [33:0]     sq_full;
  logic [15:0]            pulse_end;
  logic                   pulse_inv;

  // ring memory: {realign mark, error}
  pdl_ring_mem #(.DEPTH(RING_DEPTH), .AW(AW), .DW(17)) u_ring (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // shared divide by ring depth, used for the mean and the variance
  pdl_div #(.DW(SQW), .SH(AW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .quotient (div_quo),
    .sts      (div_sts)
  );

  pdl_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .radicand (div_quo[31:0]),
    .root     (root_val),
    .sts      (root_sts)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_align_r  <= MAX_ALIGN_RST;
      settle_lim_r <= SETTLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_ALIGN: max_align_r  <= cfg_data;
        CFG_SETTLE:    settle_lim_r <= cfg_data;
        default:       ;
      endcase
    end
  end

  // wrapped fine phase error, saturated to 16 bits
  always_comb begin
    ph_d  = $signed({2'b00, rph_r}) - $signed({2'b00, lph_r});
    ph_w1 = (ph_d > DW'(P2_HI)) ? ph_d - DW'(P2) : ph_d;
    ph_w2 = (ph_w1 < DW'(P2_LO)) ? ph_w1 + DW'(P2) : ph_w1;
    if (ph_w2 > DW'(ERR_MAX)) begin
      err_sat = 16'(ERR_MAX);
    end else if (ph_w2 < DW'(ERR_MIN)) begin
      err_sat = 16'(ERR_MIN);
    end else begin
      err_sat = ph_w2[15:0];
    end
  end

  // wrapped coarse gap magnitude
  always_comb begin
    gap_d   = $signed({2'b00, rc_r}) - $signed({2'b00, lc_r});
    gap_w1  = (gap_d > GW'(P1_HI)) ? gap_d - GW'(COARSE_PERIOD) : gap_d;
    gap_w2  = (gap_w1 < GW'(P1_LO)) ? gap_w1 + GW'(COARSE_PERIOD) : gap_w1;
    gap_abs = gap_w2[GW-1] ? -gap_w2 : gap_w2;
  end

  // error change; a realign clears the previous error first
  assign change = 17'(err_r) - (mark_r ? 17'sd0 : 17'(last_err_r));

  assign sum_abs  = sum_r[SUMW-1] ? -sum_r : sum_r;
  assign rd_err_x = 17'($signed(mem_rdata[15:0]));
  assign sq_full  = d_r * d_r;

  // output pulse placement
  always_comb begin
    if (offset_r < 16'(COARSE_PERIOD - PW)) begin
      pulse_end = offset_r + 16'(PW);
      pulse_inv = 1'b0;
    end else begin
      pulse_end = offset_r - 16'(COARSE_PERIOD - PW - 1);
      pulse_inv = 1'b1;
    end
  end

  assign walk_end = (walk_r == DEPTH_C);

  // sequencer: next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:     if (clr_r == LAST_C) state_nxt = ST_IDLE;
      ST_IDLE:      if (in_valid) state_nxt = ST_PROD;
      ST_PROD:      state_nxt = ST_ERR;
      ST_ERR:       state_nxt = ST_UPD;
      ST_UPD:       state_nxt = ST_SUM;
      ST_SUM:       if (walk_end && !rd_vld_r) state_nxt = ST_MDIV_GO;
      ST_MDIV_GO:   state_nxt = ST_MDIV_WAIT;
      ST_MDIV_WAIT: if (div_sts.done) state_nxt = ST_SQ;
      ST_SQ: begin
        if (walk_end && !rd_vld_r && !d_vld_r && !p_vld_r) state_nxt = ST_VDIV_GO;
      end
      ST_VDIV_GO:   state_nxt = ST_VDIV_WAIT;
      ST_VDIV_WAIT: if (div_sts.done) state_nxt = ST_ROOT_GO;
      ST_ROOT_GO:   state_nxt = ST_ROOT_WAIT;
      ST_ROOT_WAIT: if (root_sts.done) state_nxt = ST_DONE;
      ST_DONE:      if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:      state_nxt = ST_CLEAR;
    endcase
  end

  // sequencer: control outputs
  always_comb begin
    mem_we       = 1'b0;
    mem_waddr    = ptr_r;
    mem_wdata    = {mark_r, err_r};
    mem_raddr    = walk_r[AW-1:0];
    walk_issue   = 1'b0;
    div_start    = 1'b0;
    div_dividend = sq_r;
    root_start   = 1'b0;
    out_load     = 1'b0;
    in_stall     = 1'b1;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
      end
      ST_IDLE:    in_stall = 1'b0;
      ST_UPD:     mem_we = 1'b1;
      ST_SUM:     walk_issue = !walk_end;
      ST_MDIV_GO: begin
        div_start    = 1'b1;
        div_dividend = SQW'($unsigned(sum_abs));
      end
      ST_SQ:      walk_issue = !walk_end;
      ST_VDIV_GO: div_start = 1'b1;
      ST_ROOT_GO: root_start = 1'b1;
      ST_DONE:    out_load = !out_valid_r || !out_stall;
      default:    ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_r      <= '0;
      dac_r      <= DAC_MID;
      last_err_r <= '0;
      offset_r   <= '0;
      ptr_r      <= '0;
      sec_r      <= '0;
      rd_vld_r   <= 1'b0;
      d_vld_r    <= 1'b0;
      p_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= walk_issue;
      d_vld_r  <= rd_vld_r && (state_r == ST_SQ);
      p_vld_r  <= d_vld_r;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (state_r == ST_UPD) begin
        // bang-bang step on the error change, clamped at the rails
        if (sense_r) begin
          if (change <= 17'sd0 && dac_r != DAC_MAX) dac_r <= dac_r + 1'b1;
        end else begin
          if (change >= 17'sd0 && dac_r != '0) dac_r <= dac_r - 1'b1;
        end
        last_err_r <= err_r;
        if (mark_r) offset_r <= rc_r;
        ptr_r <= (ptr_r == LAST_C) ? '0 : ptr_r + 1'b1;
        sec_r <= sec_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      rc_r    <= in_ref_coarse;
      rf_r    <= in_ref_fine;
      lc_r    <= in_loop_coarse;
      lf_r    <= in_loop_fine;
      sense_r <= in_sense_bit;
    end
    if (state_r == ST_PROD) begin
      rph_r <= PHW'(rc_r * FINE_DIVISOR) + PHW'(rf_r);
      lph_r <= PHW'(lc_r * FINE_DIVISOR) + PHW'(lf_r);
    end
    if (state_r == ST_ERR) begin
      err_r  <= err_sat;
      mark_r <= (gap_abs > GW'(max_align_r));
    end
    if (walk_issue) begin
      walk_r <= walk_r + 1'b1;
    end
    // first walk: sum and lock
    if (state_r == ST_UPD) begin
      walk_r <= '0;
      sum_r  <= '0;
      lock_r <= 1'b1;
    end
    if (state_r == ST_SUM && rd_vld_r) begin
      sum_r <= sum_r + SUMW'(rd_err_x);
      if (mem_rdata[16]) lock_r <= 1'b0;
    end
    // mean truncated toward zero
    if (state_r == ST_MDIV_WAIT && div_sts.done) begin
      mean_r <= sum_r[SUMW-1] ? -div_quo[15:0] : div_quo[15:0];
      walk_r <= '0;
      sq_r   <= '0;
    end
    // second walk: squared deviation
    if (state_r == ST_SQ && rd_vld_r) begin
      d_r <= rd_err_x - 17'(mean_r);
    end
    if (d_vld_r) begin
      sqp_r <= sq_full[31:0];
    end
    if (p_vld_r) begin
      sq_r <= sq_r + SQW'(sqp_r);
    end
    if (out_load) begin
      out_dac_r     <= dac_r;
      out_start_r   <= offset_r;
      out_end_r     <= pulse_end;
      out_inv_r     <= pulse_inv;
      out_mark_r    <= mark_r;
      out_err_r     <= err_r;
      out_mean_r    <= mean_r;
      out_rms_r     <= root_val;
      out_locked_r  <= lock_r;
      out_settled_r <= lock_r && (root_val <= settle_lim_r);
      out_sec_r     <= sec_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_dac_code       = out_dac_r;
  assign out_pulse_start    = out_start_r;
  assign out_pulse_end      = out_end_r;
  assign out_pulse_inverted = out_inv_r;
  assign out_realigned      = out_mark_r;
  assign out_phase_error    = out_err_r;
  assign out_mean_error     = out_mean_r;
  assign out_rms_error      = out_rms_r;
  assign out_locked         = out_locked_r;
  assign out_settled        = out_settled_r;
  assign out_second_count   = out_sec_r;

`include "pps_discipline_loop_assert.svh"

  // settled only ever reported together with lock
  `PDL_ASSERT_NOW(a_settled_locked, out_valid, !out_settled || out_locked)
  // an accepted item makes the block busy on the next cycle
  `PDL_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  // arithmetic units are quiet while idle
  `PDL_ASSERT_NOW(a_units_idle, state_r == ST_IDLE, !div_sts.busy && !root_sts.busy)

endmodule

// ===== bench/pps_discipline_loop_tb.sv =====
// ----------------------------------------------------------------------------
// pps_discipline_loop_tb
// self-checking bench: drives capture items with random gaps, predicts every
// result from an internal copy of the loop state and compares field by field
// ----------------------------------------------------------------------------
module pps_discipline_loop_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pdl_pkg::*;

  localparam int DEPTH     = 64;
  localparam int FDIV      = 400;
  localparam int PERIOD    = 62500;
  localparam int WATCHDOG  = 20000;

  typedef struct packed {
    logic [11:0] dac;
    logic [15:0] pstart;
    logic [15:0] pend;
    logic        pinv;
    logic        realign;
    logic [15:0] perr;
    logic [15:0] merr;
    logic [15:0] rms;
    logic        lock;
    logic        settle;
    logic [7:0]  secs;
  } loop_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] in_ref_coarse = '0;
  logic [8:0]  in_ref_fine = '0;
  logic [15:0] in_loop_coarse = '0;
  logic [8:0]  in_loop_fine = '0;
  logic in_sense_bit = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [11:0] out_dac_code;
  logic [15:0] out_pulse_start, out_pulse_end;
  logic out_pulse_inverted, out_realigned;
  logic signed [15:0] out_phase_error, out_mean_error;
  logic [15:0] out_rms_error;
  logic out_locked, out_settled;
  logic [7:0] out_second_count;

  // predictor state
  int unsigned m_align, m_settle_lim;
  int unsigned m_dac, m_offset, m_ptr, m_secs;
  longint      m_last;
  longint      m_ring [DEPTH];
  bit          m_marks [DEPTH];

  loop_result_t expected_q [$];
  int  error_count = 0;
  int  idle_cycles = 0;
  bit  hold_off = 1'b0;

  always #5 clk = ~clk;

  pps_discipline_loop i_dut (.*);

  // accepted-nothing watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic longint wrap_gap(longint d, longint p);
    if (d > p - p / 2 - 1) d -= p;
    if (d < -(p / 2)) d += p;
    return d;
  endfunction

  function automatic longint int_root(longint v);
    longint r = 0;
    longint b = 64'sd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic model_reset();
    m_align = MAX_ALIGN_RST;
    m_settle_lim = SETTLE_RST;
    m_dac = DAC_MID;
    m_last = 0;
    m_offset = 0;
    m_ptr = 0;
    m_secs = 0;
    for (int i = 0; i < DEPTH; i++) begin
      m_ring[i] = 0;
      m_marks[i] = 1'b0;
    end
  endtask

  // advance the loop model by one pps edge and queue the result item
  task automatic predict_edge(int rc, int rf, int lc, int lf, bit sense);
    longint gap, err, chg, sum, mean, sq, dv, root;
    bit mark, lk;
    int unsigned pend;
    loop_result_t r;
    gap = wrap_gap(longint'(rc) - lc, PERIOD);
    if (gap < 0) gap = -gap;
    mark = gap > m_align;
    if (mark) begin
      m_offset = rc;
      m_last = 0;
    end
    m_marks[m_ptr] = mark;
    err = wrap_gap((longint'(rc) * FDIV + rf) - (longint'(lc) * FDIV + lf),
                   longint'(PERIOD) * FDIV);
    if (err > ERR_MAX) err = ERR_MAX;
    if (err < ERR_MIN) err = ERR_MIN;
    chg = err - m_last;
    if (sense) begin
      if (chg <= 0 && m_dac < DAC_MAX) m_dac++;
    end else begin
      if (chg >= 0 && m_dac > 0) m_dac--;
    end
    m_last = err;
    m_ring[m_ptr] = err;
    m_ptr = (m_ptr + 1) % DEPTH;
    sum = 0;
    lk = 1'b1;
    for (int i = 0; i < DEPTH; i++) begin
      sum += m_ring[i];
      if (m_marks[i]) lk = 1'b0;
    end
    mean = sum / DEPTH;
    sq = 0;
    for (int i = 0; i < DEPTH; i++) begin
      dv = m_ring[i] - mean;
      sq += dv * dv;
    end
    root = int_root(sq / DEPTH);
    if (root > 65535) root = 65535;
    m_secs = (m_secs + 1) & 8'hff;
    if (m_offset < PERIOD - PERIOD / 10) begin
      pend = m_offset + PERIOD / 10;
      r.pinv = 1'b0;
    end else begin
      pend = m_offset - (PERIOD - PERIOD / 10 - 1);
      r.pinv = 1'b1;
    end
    r.dac = m_dac[11:0];
    r.pstart = m_offset[15:0];
    r.pend = pend[15:0];
    r.realign = mark;
    r.perr = err[15:0];
    r.merr = mean[15:0];
    r.rms = root[15:0];
    r.lock = lk;
    r.settle = lk && (root <= m_settle_lim);
    r.secs = m_secs[7:0];
    expected_q.push_back(r);
  endtask

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", field, got, want);
    error_count++;
  endtask

  // result checker with random stall and the long hold-off
  initial begin
    loop_result_t w;
    int gap;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result item", 1, 0);
        end else begin
          w = expected_q.pop_front();
          if (out_dac_code != w.dac) report_mismatch("dac_code", out_dac_code, w.dac);
          if (out_pulse_start != w.pstart)
            report_mismatch("pulse_start", out_pulse_start, w.pstart);
          if (out_pulse_end != w.pend) report_mismatch("pulse_end", out_pulse_end, w.pend);
          if (out_pulse_inverted != w.pinv)
            report_mismatch("pulse_inverted", out_pulse_inverted, w.pinv);
          if (out_realigned != w.realign)
            report_mismatch("realigned", out_realigned, w.realign);
          if (out_phase_error != $signed(w.perr))
            report_mismatch("phase_error", out_phase_error, $signed(w.perr));
          if (out_mean_error != $signed(w.merr))
            report_mismatch("mean_error", out_mean_error, $signed(w.merr));
          if (out_rms_error != w.rms) report_mismatch("rms_error", out_rms_error, w.rms);
          if (out_locked != w.lock) report_mismatch("locked", out_locked, w.lock);
          if (out_settled != w.settle) report_mismatch("settled", out_settled, w.settle);
          if (out_second_count != w.secs)
            report_mismatch("second_count", out_second_count, w.secs);
        end
        // stall after each taken item, none at times
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        if (gap > 0) out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
        if (hold_off) begin
          out_stall <= 1'b1;
          repeat (3000) @(posedge clk);
        end
        out_stall <= 1'b0;
      end
    end
  end

  // send one capture item, with a random gap before it unless no_gap is set; valid drops for the gap
  task automatic send_edge(int rc, int rf, int lc, int lf, bit sense, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ref_coarse <= rc[15:0];
    in_ref_fine <= rf[8:0];
    in_loop_coarse <= lc[15:0];
    in_loop_fine <= lf[8:0];
    in_sense_bit <= sense;
    predict_edge(rc, rf, lc, lf, sense);
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[15:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MAX_ALIGN) m_align = val & 16'hffff;
    else m_settle_lim = val & 16'hffff;
    @(posedge clk);
  endtask

  // field extremes, wrap edges, realign and saturation cases
  task automatic test_directed();
    send_edge(0, 0, 0, 0, 1);
    send_edge(62499, 399, 62499, 399, 0);
    send_edge(0, 0, 62499, 399, 1);          // wrap across period, small error
    send_edge(62499, 399, 0, 0, 0);
    send_edge(31249, 0, 0, 0, 1);            // upper wrap bound
    send_edge(31250, 0, 0, 0, 0);
    send_edge(0, 0, 31250, 0, 1);            // lower wrap bound
    send_edge(0, 0, 31251, 0, 1);
    send_edge(100, 0, 98, 0, 1);             // gap at limit, no realign
    send_edge(100, 0, 97, 0, 0);             // gap just over limit
    send_edge(100, 399, 100, 0, 1);          // fine only error
    send_edge(200, 0, 100, 0, 0);            // positive saturation
    send_edge(100, 0, 200, 0, 1);            // negative saturation
    send_edge(56249, 0, 56249, 0, 1);        // equal captures, no realign
    send_edge(56250, 0, 56000, 0, 0);        // pulse wraps, inverted
    send_edge(65535, 511, 0, 0, 1);          // out of range captures
    send_edge(0, 511, 65535, 511, 0);
    for (int i = 0; i < 6; i++) send_edge(500, 10, 500, 10, 1);
    wait_drained();
  endtask

  // walk the dac up and then down with constant error, items back to back
  task automatic test_dac_clamps();
    write_reg(CFG_MAX_ALIGN, 65535);
    write_reg(CFG_SETTLE, 65535);
    for (int i = 0; i < 20; i++) send_edge(7, 3, 7, 3, 1, 1);
    wait_drained();
    write_reg(CFG_MAX_ALIGN, 0);
    write_reg(CFG_SETTLE, 0);
    for (int i = 0; i < 20; i++) send_edge(9, 0, 9, 0, 0, 1);
    wait_drained();
  endtask

  // mostly near-locked edges with random jitter, some far noise
  task automatic test_random(int count, int align, int lim);
    int rc, rf, lc, lf;
    write_reg(CFG_MAX_ALIGN, align);
    write_reg(CFG_SETTLE, lim);
    for (int i = 0; i < count; i++) begin
      rc = $urandom_range(0, 62499);
      rf = $urandom_range(0, 399);
      if ($urandom_range(0, 9) < 8) begin
        lc = (rc + $urandom_range(0, 4) - 2 + 62500) % 62500;
        lf = $urandom_range(0, 399);
      end else if ($urandom_range(0, 9) == 0) begin
        lc = $urandom_range(0, 65535);
        rc = $urandom_range(0, 65535);
        rf = $urandom_range(0, 511);
        lf = $urandom_range(0, 511);
      end else begin
        lc = $urandom_range(0, 62499);
        lf = $urandom_range(0, 399);
      end
      send_edge(rc, rf, lc, lf, $urandom_range(0, 1));
    end
    wait_drained();
  endtask

  // receiver holds off for a long stretch while items keep coming
  task automatic test_backpressure();
    hold_off = 1'b1;
    for (int i = 0; i < 6; i++) send_edge(1000 + i, 5, 1000, 5, i[0], 1);
    hold_off = 1'b0;
    wait_drained();
  endtask

  initial begin
    model_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_dac_clamps();
    test_backpressure();
    test_random(100, 2, 25);
    test_random(100, 0, 400);
    test_random(100, 65535, 0);
    test_random(20, 5, 65535);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
